FILE: rtl/dwf_pkg.sv
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types and constants for the frame deframer: the operation record
// that travels from the header parser to the payload stage, and its queue.
// ----------------------------------------------------------------------------
package dwf_pkg;

	localparam logic [7:0] HDR_TEXT_FINAL = 8'h81;
	localparam logic [6:0] LEN_EXT16      = 7'd126;
	localparam logic [6:0] LEN_EXT64      = 7'd127;
	localparam logic [7:0] DRAFT_OPEN     = 8'h00;
	localparam logic [7:0] DRAFT_CLOSE    = 8'hFF;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_KEY    = 3'd0,
		OP_EMPTY  = 3'd1,
		OP_PAY    = 3'd2,
		OP_DSTART = 3'd3,
		OP_DDATA  = 3'd4,
		OP_DEND   = 3'd5
	} dwf_kind_t;

	typedef struct packed {
		dwf_kind_t   kind;
		logic [7:0]  data;
		logic        fin;
		logic [1:0]  pos;
		logic        masked;
	} dwf_op_t;

endpackage

FILE: rtl/dwf_front.sv
// ----------------------------------------------------------------------------
// dwf_front
// Header parser: accepts stream bytes, tracks frame phase and length, and
// turns key, payload and frame-boundary bytes into payload-stage operations.
// ----------------------------------------------------------------------------
module dwf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            push_valid,
	output dwf_pkg::dwf_op_t push_op
);
	import dwf_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN     = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DRAFT   = 3'd5
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        mode_q;
	logic [63:0] rem_q, rem_n, rem_sh, rem_dec;
	logic [2:0]  lbl_q, lbl_n;
	logic [1:0]  pos_q, pos_n;
	logic        mp_q, mp_n;
	logic        push;
	dwf_op_t     op;
	logic        accept;

	assign in_ready = !q_full && !cfg_valid;
	assign accept   = in_valid && in_ready;
	assign rem_sh   = {rem_q[55:0], in_byte};
	assign rem_dec  = rem_q - 64'd1;

	always_comb begin
		phase_n   = phase_q;
		rem_n     = rem_q;
		lbl_n     = lbl_q;
		pos_n     = pos_q;
		mp_n      = mp_q;
		push      = 1'b0;
		op.kind   = OP_KEY;
		op.data   = in_byte;
		op.fin    = 1'b0;
		op.pos    = pos_q;
		op.masked = mp_q;
		if (mode_q) begin
			unique case (phase_q)
				PH_LEN: begin
					mp_n  = in_byte[7];
					rem_n = '0;
					if (in_byte[6:0] == LEN_EXT16) begin
						lbl_n   = 3'd1;
						phase_n = PH_EXTLEN;
					end else if (in_byte[6:0] == LEN_EXT64) begin
						lbl_n   = 3'd7;
						phase_n = PH_EXTLEN;
					end else begin
						rem_n = {57'd0, in_byte[6:0]};
						pos_n = 2'd0;
						if (in_byte[7]) begin
							phase_n = PH_MASK;
						end else if (in_byte[6:0] == 7'd0) begin
							phase_n = PH_HUNT;
							push    = 1'b1;
							op.kind = OP_EMPTY;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				end
				PH_EXTLEN: begin
					rem_n = rem_sh;
					if (lbl_q != 3'd0) begin
						lbl_n = lbl_q - 3'd1;
					end else begin
						pos_n = 2'd0;
						if (mp_q) begin
							phase_n = PH_MASK;
						end else if (rem_sh == 64'd0) begin
							phase_n = PH_HUNT;
							push    = 1'b1;
							op.kind = OP_EMPTY;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				end
				PH_MASK: begin
					push    = 1'b1;
					op.kind = OP_KEY;
					op.fin  = (pos_q == 2'd3) && (rem_q == 64'd0);
					if (pos_q != 2'd3) begin
						pos_n = pos_q + 2'd1;
					end else begin
						pos_n   = 2'd0;
						phase_n = (rem_q == 64'd0) ? PH_HUNT : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					push    = 1'b1;
					op.kind = OP_PAY;
					op.fin  = (rem_dec == 64'd0);
					pos_n   = pos_q + 2'd1;
					rem_n   = rem_dec;
					if (rem_dec == 64'd0) begin
						phase_n = PH_HUNT;
					end
				end
				default: begin
					phase_n = (in_byte == HDR_TEXT_FINAL) ? PH_LEN : PH_HUNT;
				end
			endcase
		end else begin
			if (phase_q != PH_DRAFT) begin
				if (in_byte == DRAFT_OPEN) begin
					phase_n = PH_DRAFT;
					push    = 1'b1;
					op.kind = OP_DSTART;
				end else begin
					phase_n = PH_HUNT;
				end
			end else if (in_byte == DRAFT_CLOSE) begin
				phase_n = PH_HUNT;
				push    = 1'b1;
				op.kind = OP_DEND;
			end else begin
				push    = 1'b1;
				op.kind = OP_DDATA;
			end
		end
	end

	assign push_valid = accept && push;
	assign push_op    = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mode_q  <= 1'b1;
			rem_q   <= '0;
			lbl_q   <= '0;
			pos_q   <= '0;
			mp_q    <= 1'b0;
		end else if (cfg_valid) begin
			mode_q  <= cfg_data;
			phase_q <= PH_HUNT;
		end else if (accept) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			lbl_q   <= lbl_n;
			pos_q   <= pos_n;
			mp_q    <= mp_n;
		end
	end

endmodule

FILE: rtl/dwf_queue.sv
// ----------------------------------------------------------------------------
// dwf_queue
// Short operation queue between the header parser and the payload stage.
// ----------------------------------------------------------------------------
module dwf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dwf_pkg::dwf_op_t push_op,
	input  logic             pop,
	output logic             head_valid,
	output dwf_pkg::dwf_op_t head_op,
	output logic             full
);
	import dwf_pkg::*;

	dwf_op_t         slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == Q_CW'(Q_DEPTH));
	assign head_op    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/dwf_back.sv
// ----------------------------------------------------------------------------
// dwf_back
// Payload stage: holds the mask key and the draft look-behind byte, unmasks
// payload bytes and drives the registered result channel.
// ----------------------------------------------------------------------------
module dwf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             head_valid,
	input  dwf_pkg::dwf_op_t head_op,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       payload_byte,
	output logic             last_byte,
	output logic             empty_frame
);
	import dwf_pkg::*;

	logic [31:0] key_q;
	logic [7:0]  held_q;
	logic        held_valid_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_empty_q;
	logic [7:0]  key_byte;
	logic        e_valid;
	logic [7:0]  e_byte;
	logic        e_last;
	logic        e_empty;

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		case (head_op.pos)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		if (!head_op.masked) begin
			key_byte = 8'd0;
		end
	end

	always_comb begin
		e_valid = 1'b0;
		e_byte  = 8'd0;
		e_last  = 1'b0;
		e_empty = 1'b0;
		unique case (head_op.kind)
			OP_KEY: begin
				e_valid = head_op.fin;
				e_last  = 1'b1;
				e_empty = 1'b1;
			end
			OP_EMPTY: begin
				e_valid = 1'b1;
				e_last  = 1'b1;
				e_empty = 1'b1;
			end
			OP_PAY: begin
				e_valid = 1'b1;
				e_byte  = head_op.data ^ key_byte;
				e_last  = head_op.fin;
			end
			OP_DDATA: begin
				e_valid = held_valid_q;
				e_byte  = held_q;
			end
			OP_DEND: begin
				e_valid = 1'b1;
				e_last  = 1'b1;
				e_byte  = held_valid_q ? held_q : 8'd0;
				e_empty = !held_valid_q;
			end
			default: begin
				e_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (clear) begin
				held_valid_q <= 1'b0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (e_valid) begin
					out_valid_q <= 1'b1;
				end
				case (head_op.kind)
					OP_KEY:    key_q        <= {key_q[23:0], head_op.data};
					OP_DSTART: held_valid_q <= 1'b0;
					OP_DDATA: begin
						held_q       <= head_op.data;
						held_valid_q <= 1'b1;
					end
					OP_DEND:   held_valid_q <= 1'b0;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && e_valid) begin
			out_byte_q  <= e_byte;
			out_last_q  <= e_last;
			out_empty_q <= e_empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign last_byte    = out_last_q;
	assign empty_frame  = out_empty_q;

endmodule

FILE: rtl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Path: operation queue, then the registered result channel.
// Throughput: one byte per cycle while the queue has room and cfg_valid is
// low; the payload stage retires one queued operation per cycle while its
// result is free or taken, and a four-entry queue absorbs output stalls.
// Reset: asynchronous; RFC 6455 mode, parser hunting, queue and result empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       last_byte,
	output logic       empty_frame
);
	import dwf_pkg::*;

	logic    q_full;
	logic    push_valid;
	dwf_op_t push_op;
	logic    head_valid;
	dwf_op_t head_op;
	logic    pop;

	assign cfg_ready = 1'b1;

	dwf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_op    (push_op)
	);

	dwf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_op    (push_op),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.full       (q_full)
	);

	dwf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_valid),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.empty_frame  (empty_frame)
	);

endmodule

FILE: tb/websocket_frame_deframer_checker.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches the mode, byte and payload channels of the frame deframer. It keeps
// its own copy of the frame parser, queues the payload results each accepted
// byte must produce, and compares every accepted result against the oldest
// queued one, field by field. It hands the mismatch count and the number of
// results still due to the testbench top.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] payload_byte,
	input  logic       last_byte,
	input  logic       empty_frame,
	output int         due_count,
	output int         fail_count
);
	import dwf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		SEEK   = 3'd0,
		LENGTH = 3'd1,
		EXTLEN = 3'd2,
		KEYS   = 3'd3,
		BODY   = 3'd4,
		DRAFT  = 3'd5
	} parse_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       empty;
	} deframed_t;

	deframed_t   due_bytes[$];
	deframed_t   want;
	int          errs = 0;

	logic        rfc_mode;
	parse_t      phase;
	logic [63:0] len_left;
	logic [2:0]  ext_cnt;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic        keyed;
	logic [7:0]  hold_byte;
	logic        hold_vld;

	task add_due(input logic [7:0] data, input logic fin, input logic empty);
		deframed_t d;
		d.data  = data;
		d.fin   = fin;
		d.empty = empty;
		due_bytes.push_back(d);
	endtask

	task report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
		$display("%0t mismatch: %s got %0h expected %0h", $time, what, got, exp_val);
		errs++;
	endtask

	task close_header();
		key_pos = 2'd0;
		if (len_left == 64'd0) begin
			phase = SEEK;
			add_due(8'h00, 1'b1, 1'b1);
		end else begin
			phase = BODY;
		end
	endtask

	task unframe_rfc(input logic [7:0] b);
		logic [7:0] kb;
		case (phase)
			LENGTH: begin
				keyed    = b[7];
				len_left = 64'd0;
				if (b[6:0] == LEN_EXT16) begin
					ext_cnt = 3'd1;
					phase   = EXTLEN;
				end else if (b[6:0] == LEN_EXT64) begin
					ext_cnt = 3'd7;
					phase   = EXTLEN;
				end else begin
					len_left = {57'd0, b[6:0]};
					if (keyed) begin
						key_pos = 2'd0;
						phase   = KEYS;
					end else begin
						close_header();
					end
				end
			end
			EXTLEN: begin
				len_left = {len_left[55:0], b};
				if (ext_cnt != 3'd0) begin
					ext_cnt = ext_cnt - 3'd1;
				end else if (keyed) begin
					key_pos = 2'd0;
					phase   = KEYS;
				end else begin
					close_header();
				end
			end
			KEYS: begin
				key = {key[23:0], b};
				if (key_pos != 2'd3)
					key_pos = key_pos + 2'd1;
				else
					close_header();
			end
			BODY: begin
				kb = 8'h00;
				if (keyed)
					kb = 8'(key >> (24 - 8 * int'(key_pos)));
				key_pos  = key_pos + 2'd1;
				len_left = len_left - 64'd1;
				if (len_left == 64'd0) begin
					phase = SEEK;
					add_due(b ^ kb, 1'b1, 1'b0);
				end else begin
					add_due(b ^ kb, 1'b0, 1'b0);
				end
			end
			default: begin
				phase = (b == HDR_TEXT_FINAL) ? LENGTH : SEEK;
			end
		endcase
	endtask

	task unframe_draft(input logic [7:0] b);
		logic [7:0] prev;
		if (phase != DRAFT) begin
			if (b == DRAFT_OPEN) begin
				phase    = DRAFT;
				hold_vld = 1'b0;
			end else begin
				phase = SEEK;
			end
		end else if (b == DRAFT_CLOSE) begin
			phase = SEEK;
			if (hold_vld) begin
				hold_vld = 1'b0;
				add_due(hold_byte, 1'b1, 1'b0);
			end else begin
				add_due(8'h00, 1'b1, 1'b1);
			end
		end else begin
			prev      = hold_byte;
			hold_byte = b;
			if (hold_vld)
				add_due(prev, 1'b0, 1'b0);
			else
				hold_vld = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rfc_mode  = 1'b1;
			phase     = SEEK;
			len_left  = 64'd0;
			ext_cnt   = 3'd0;
			key       = 32'd0;
			key_pos   = 2'd0;
			keyed     = 1'b0;
			hold_byte = 8'h00;
			hold_vld  = 1'b0;
			due_bytes.delete();
			due_count  <= 0;
			fail_count <= errs;
		end else begin
			if (out_valid && out_ready) begin
				if (due_bytes.size() == 0) begin
					report("result with nothing due", payload_byte, 8'h00);
				end else begin
					want = due_bytes.pop_front();
					if (payload_byte !== want.data)
						report("payload_byte", payload_byte, want.data);
					if (last_byte !== want.fin)
						report("last_byte", {7'd0, last_byte}, {7'd0, want.fin});
					if (empty_frame !== want.empty)
						report("empty_frame", {7'd0, empty_frame}, {7'd0, want.empty});
				end
			end
			if (cfg_valid && cfg_ready) begin
				rfc_mode = cfg_data;
				phase    = SEEK;
				hold_vld = 1'b0;
			end
			if (in_valid && in_ready) begin
				if (rfc_mode)
					unframe_rfc(in_byte);
				else
					unframe_draft(in_byte);
			end
			due_count  <= due_bytes.size();
			fail_count <= errs;
		end
	end

endmodule

FILE: tb/websocket_frame_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_tb
// Drives the frame deframer with directed frames in both framing modes, then
// with random phases of well-formed frames mixed with noise, cut-off frames
// and oversized frames, switching the mode between phases. The sender works
// in bursts and the receiver stalls on a changing pattern; a checker beside
// the block predicts and compares every payload result.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_tb;

	import dwf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ITEMS    = 1850;
	localparam int          DRAIN    = 12;
	localparam int unsigned LIMIT    = 600000;
	localparam logic [7:0]  MASK_BIT = 8'h80;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic       last_byte;
	logic       empty_frame;

	int          due_count;
	int          fail_count;
	int unsigned cyc = 0;
	int          stall_run = 0;
	int          stall_style = 0;
	int          burst_left = 0;
	int          framed = 0;
	logic        mode_now = 1'b1;
	logic [7:0]  burst_q[$];

	websocket_frame_deframer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.empty_frame  (empty_frame)
	);

	websocket_frame_deframer_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.empty_frame  (empty_frame),
		.due_count    (due_count),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// change the stall pattern after each run of random length
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_run   <= $urandom_range(16, 200);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_style)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cyc[2:0] != 3'd0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
			                                          : $urandom_range(0, 12);
		end
	endtask

	task automatic send_queue(input bit counted);
		while (burst_q.size() != 0) begin
			send_byte(burst_q.pop_front());
			if (counted)
				framed++;
		end
	endtask

	// hold until every due result is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_now = m;
	endtask

	task automatic rfc_frame(input bit broken);
		int          form;
		int          len;
		int          keep;
		logic [63:0] len64;
		logic        masked;
		form   = $urandom_range(0, 3);
		masked = 1'($urandom_range(0, 1));
		len    = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
		if (form < 2 && $urandom_range(0, 9) == 0)
			len = $urandom_range(100, 125);
		if (form == 2 && $urandom_range(0, 9) == 0)
			len = $urandom_range(126, 400);
		len64 = 64'(len);
		burst_q.push_back(HDR_TEXT_FINAL);
		if (form < 2) begin
			burst_q.push_back({masked, len64[6:0]});
		end else if (form == 2) begin
			burst_q.push_back({masked, LEN_EXT16});
			burst_q.push_back(len64[15:8]);
			burst_q.push_back(len64[7:0]);
		end else begin
			burst_q.push_back({masked, LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				burst_q.push_back(len64[8 * i +: 8]);
		end
		if (masked)
			repeat (4) burst_q.push_back(8'($urandom_range(0, 255)));
		repeat (len) burst_q.push_back(8'($urandom_range(0, 255)));
		if (broken && burst_q.size() > 1) begin
			keep = $urandom_range(1, burst_q.size() - 1);
			while (burst_q.size() > keep) void'(burst_q.pop_back());
		end
		send_queue(1'b1);
	endtask

	// leave the parser inside a frame whose 64-bit length never runs out
	task automatic huge_frame();
		logic masked;
		masked = 1'($urandom_range(0, 1));
		burst_q.push_back(HDR_TEXT_FINAL);
		burst_q.push_back({masked, LEN_EXT64});
		burst_q.push_back(8'($urandom_range(1, 255)));
		repeat (7) burst_q.push_back(8'($urandom_range(0, 255)));
		if (masked)
			repeat (4) burst_q.push_back(8'($urandom_range(0, 255)));
		repeat ($urandom_range(5, 40)) burst_q.push_back(8'($urandom_range(0, 255)));
		send_queue(1'b1);
	endtask

	task automatic draft_frame(input bit broken);
		int         len;
		logic [7:0] b;
		len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
		burst_q.push_back(DRAFT_OPEN);
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			burst_q.push_back((b == DRAFT_CLOSE) ? 8'h7F : b);
		end
		if (!broken)
			burst_q.push_back(DRAFT_CLOSE);
		send_queue(1'b1);
	endtask

	task automatic noise();
		logic [7:0] b;
		bit         raw;
		raw = ($urandom_range(0, 7) == 0);
		repeat ($urandom_range(1, 4)) begin
			b = 8'($urandom_range(0, 255));
			if (!raw && mode_now && b == HDR_TEXT_FINAL)
				b = 8'h01;
			if (!raw && !mode_now && b == DRAFT_OPEN)
				b = 8'h01;
			burst_q.push_back(b);
		end
		send_queue(1'b0);
	endtask

	initial begin
		int pick;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_q = '{HDR_TEXT_FINAL, MASK_BIT, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
		            HDR_TEXT_FINAL, 8'h02, 8'h00, 8'hFF,
		            HDR_TEXT_FINAL, {1'b1, LEN_EXT16}, 8'h00, 8'h02,
		            8'hFF, 8'h00, 8'h5A, 8'hA5, HDR_TEXT_FINAL, DRAFT_OPEN,
		            HDR_TEXT_FINAL, {1'b0, LEN_EXT16}};
		send_queue(1'b1);
		set_mode(1'b0);
		burst_q = '{DRAFT_OPEN, DRAFT_CLOSE,
		            DRAFT_OPEN, HDR_TEXT_FINAL, DRAFT_OPEN, DRAFT_CLOSE,
		            DRAFT_OPEN, 8'h77};
		send_queue(1'b1);
		set_mode(1'b1);

		while (framed < ITEMS) begin
			set_mode(1'($urandom_range(0, 1)));
			repeat ($urandom_range(3, 12)) begin
				pick = $urandom_range(0, 11);
				if (pick == 0)
					noise();
				else if (mode_now)
					rfc_frame(pick == 1);
				else
					draft_frame(pick == 1);
			end
			if (mode_now && $urandom_range(0, 4) == 0)
				huge_frame();
		end

		settle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
